### rtl/urr_pkg.sv
// Shared types for the identifier run range encoder.
// Word layouts of both channels and the push bundle from core to queue.
// No dependencies.
package urr_pkg;

    typedef struct packed {
        logic [31:0] ident;
        logic        list_end;
    } id_word_t;

    typedef struct packed {
        logic [31:0] run_first;
        logic [31:0] run_final;
        logic        is_span;
        logic        list_done;
    } run_word_t;

    // Up to two result words per accepted identifier, packed to the front:
    // w1 is valid only when w0 is.
    typedef struct packed {
        logic      v0;
        logic      v1;
        run_word_t w0;
        run_word_t w1;
    } push_t;

endpackage

### rtl/urr_core.sv
// Run tracking state and result formation for the run range encoder.
// Depends on urr_pkg.
module urr_core
    import urr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  id_word_t word,
    output push_t    push
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_RANGE  = 2'd2
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [31:0] prev_reg, prev_next;
    logic [31:0] first_reg, first_next;
    logic [31:0] final_reg, final_next;

    logic        follows;
    logic        close_old;
    run_word_t   old_run;
    run_word_t   new_run;

    always_comb
    begin
        follows = (mode_reg != MODE_IDLE) && (word.ident != 32'd0) &&
                  (prev_reg != 32'd0) && (word.ident == prev_reg + 32'd1);
        close_old = (mode_reg != MODE_IDLE) && !follows;

        old_run.run_first = first_reg;
        old_run.run_final = final_reg;
        old_run.is_span   = (mode_reg == MODE_RANGE);
        old_run.list_done = 1'b0;

        if (follows)
        begin
            mode_next  = MODE_RANGE;
            first_next = first_reg;
        end
        else
        begin
            mode_next  = MODE_SINGLE;
            first_next = word.ident;
        end
        final_next = word.ident;
        prev_next  = word.ident;

        new_run.run_first = first_next;
        new_run.run_final = final_next;
        new_run.is_span   = (mode_next == MODE_RANGE);
        new_run.list_done = 1'b1;

        // flush on list end and drop back to idle
        if (word.list_end)
        begin
            mode_next  = MODE_IDLE;
            prev_next  = 32'd0;
            first_next = 32'd0;
            final_next = 32'd0;
        end

        push.v0 = take && (close_old || word.list_end);
        push.v1 = take && close_old && word.list_end;
        push.w0 = close_old ? old_run : new_run;
        push.w1 = new_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            prev_reg  <= 32'd0;
            first_reg <= 32'd0;
            final_reg <= 32'd0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            prev_reg  <= prev_next;
            first_reg <= first_next;
            final_reg <= final_next;
        end
    end

endmodule

### rtl/urr_outq.sv
// Four-entry result queue for the run range encoder, two writes, one read.
// Depends on urr_pkg.
module urr_outq
    import urr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    output logic      room,
    output logic      run_valid,
    input  logic      run_ready,
    output run_word_t run_word
);

    run_word_t   mem [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic        pop;
    logic [1:0]  n_push;

    always_comb
    begin
        pop         = run_valid && run_ready;
        n_push      = {1'b0, push.v0} + {1'b0, push.v1};
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, n_push} - {2'b00, pop};
    end

    assign room      = (count_reg < 3'd3);
    assign run_valid = (count_reg != 3'd0);
    assign run_word  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[wr_ptr_reg] <= push.w0;
        end
        if (push.v1)
        begin
            mem[wr_ptr_reg + 2'd1] <= push.w1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/uid_run_range_encoder.sv
// Identifier run range encoder: top level, joins run tracker and result queue.
// A result word enters the four-entry queue as its closing identifier is taken.
// Throughput: one identifier per cycle while the queue has room; a list-end
// word closing a run yields two result words, drained one per cycle on run_ready.
// Reset: rst_n clears run state and queue pointers; the block starts idle.
// Depends on urr_pkg, urr_core and urr_outq.
module uid_run_range_encoder
    import urr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      id_valid,
    output logic      id_ready,
    input  id_word_t  id_word,
    output logic      run_valid,
    input  logic      run_ready,
    output run_word_t run_word
);

    logic  take;
    push_t push;
    logic  room;

    // Accept whenever the queue holds at most two words, so both results of a
    // list-end word always fit; readiness never looks at run_ready.
    assign id_ready = room;
    assign take     = id_valid && id_ready;

    // Track the open run and form zero, one or two result words per identifier.
    urr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .word  (id_word),
        .push  (push)
    );

    // Hold result words until the consumer takes them.
    urr_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .run_valid (run_valid),
        .run_ready (run_ready),
        .run_word  (run_word)
    );

endmodule

### sim/urr_run_checker.sv
// Checker for the identifier run range encoder: watches both channels,
// predicts the run words from accepted identifiers and compares them in order.
// Depends on urr_pkg.
module urr_run_checker
    import urr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      id_valid,
    input  logic      id_ready,
    input  id_word_t  id_word,
    input  logic      run_valid,
    input  logic      run_ready,
    input  run_word_t run_word,
    output int        fault_count,
    output int        runs_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_SPAN   = 2'd2
    } run_mode_e;

    run_mode_e   mode;
    logic [31:0] last_ident;
    logic [31:0] open_lo;
    logic [31:0] open_hi;
    run_word_t   owed_runs [$];
    int          faults;

    function automatic run_word_t close_run(input logic done);
        run_word_t w;
        w.run_first = open_lo;
        w.run_final = open_hi;
        w.is_span   = (mode == MODE_SPAN);
        w.list_done = done;
        return w;
    endfunction

    task automatic open_run(input logic [31:0] ident);
        mode    = MODE_SINGLE;
        open_lo = ident;
        open_hi = ident;
    endtask

    // Advance the run state by one identifier, queueing every run it closes.
    task automatic predict_runs(input id_word_t w);
        logic follows;
        follows = (w.ident != 32'd0) && (last_ident != 32'd0) &&
                  (w.ident == last_ident + 32'd1);
        if (mode == MODE_IDLE)
            open_run(w.ident);
        else if (follows)
        begin
            mode    = MODE_SPAN;
            open_hi = w.ident;
        end
        else
        begin
            owed_runs.push_back(close_run(1'b0));
            open_run(w.ident);
        end
        last_ident = w.ident;
        if (w.list_end)
        begin
            owed_runs.push_back(close_run(1'b1));
            mode       = MODE_IDLE;
            last_ident = '0;
            open_lo    = '0;
            open_hi    = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        run_word_t want;
        if (!rst_n)
        begin
            mode       = MODE_IDLE;
            last_ident = '0;
            open_lo    = '0;
            open_hi    = '0;
            owed_runs.delete();
            faults     = 0;
        end
        else
        begin
            if (run_valid && run_ready)
            begin
                if (owed_runs.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("unexpected run word: first %h final %h span %b done %b",
                                 run_word.run_first, run_word.run_final,
                                 run_word.is_span, run_word.list_done);
                end
                else
                begin
                    want = owed_runs.pop_front();
                    if (run_word.run_first !== want.run_first ||
                        run_word.run_final !== want.run_final ||
                        run_word.is_span   !== want.is_span   ||
                        run_word.list_done !== want.list_done)
                    begin
                        faults++;
                        if (faults <= 10)
                            $display("run mismatch: want %h..%h s%b d%b, got %h..%h s%b d%b",
                                     want.run_first, want.run_final, want.is_span,
                                     want.list_done, run_word.run_first,
                                     run_word.run_final, run_word.is_span,
                                     run_word.list_done);
                    end
                end
            end
            if (id_valid && id_ready)
                predict_runs(id_word);
        end
        // Publish through nonblocking updates so readers at this edge see a stable value.
        fault_count <= faults;
        runs_owed   <= owed_runs.size();
    end

endmodule

### sim/tb.sv
// Testbench top for the identifier run range encoder: clock, reset, stimulus
// and verdict. Prediction and checking live in urr_run_checker.
// Depends on urr_pkg, uid_run_range_encoder and urr_run_checker.
module tb;
    import urr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_WORDS = 475;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      id_valid = 1'b0;
    logic      id_ready;
    id_word_t  id_word = '0;
    logic      run_valid;
    logic      run_ready = 1'b0;
    run_word_t run_word;

    int fault_count;
    int runs_owed;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int sent_words;

    logic [31:0] id_list [$];

    // Directed lists, written as {list end, identifier}:
    //   lone zero, lone top identifier, zero then one (never joined),
    //   zero then zero, plain range, range up to the top identifier followed
    //   by zero on the final word (two results there), single then range,
    //   alternating bit patterns, and a descending pair.
    logic [32:0] directed_words [19] = '{
        {1'b1, 32'h0000_0000},
        {1'b1, 32'hFFFF_FFFF},
        {1'b0, 32'h0000_0000}, {1'b1, 32'h0000_0001},
        {1'b0, 32'h0000_0000}, {1'b1, 32'h0000_0000},
        {1'b0, 32'h0000_0005}, {1'b0, 32'h0000_0006}, {1'b1, 32'h0000_0007},
        {1'b0, 32'hFFFF_FFFE}, {1'b0, 32'hFFFF_FFFF}, {1'b1, 32'h0000_0000},
        {1'b0, 32'h0000_000A}, {1'b0, 32'h0000_000C}, {1'b1, 32'h0000_000D},
        {1'b0, 32'hAAAA_AAAA}, {1'b1, 32'h5555_5555},
        {1'b0, 32'h0000_0008}, {1'b1, 32'h0000_0007}
    };

    always #1 clk = ~clk;

    uid_run_range_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .id_valid  (id_valid),
        .id_ready  (id_ready),
        .id_word   (id_word),
        .run_valid (run_valid),
        .run_ready (run_ready),
        .run_word  (run_word)
    );

    urr_run_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .id_valid    (id_valid),
        .id_ready    (id_ready),
        .id_word     (id_word),
        .run_valid   (run_valid),
        .run_ready   (run_ready),
        .run_word    (run_word),
        .fault_count (fault_count),
        .runs_owed   (runs_owed)
    );

    // Receiver: stall at random, one decision per cycle.
    always @(posedge clk)
        run_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Offer one word and hold it until accepted. Valid stays high straight
    // into the next word unless the sender chooses to idle first.
    task automatic push_id(input logic [31:0] ident, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            id_valid <= 1'b0;
            @(posedge clk);
        end
        id_valid <= 1'b1;
        id_word  <= '{ident: ident, list_end: last};
        @(posedge clk);
        while (!id_ready)
            @(posedge clk);
        sent_words++;
    endtask

    // Send the buffered list, flagging its final word, then empty the buffer.
    task automatic send_list();
        foreach (id_list[i])
            push_id(id_list[i], i == id_list.size() - 1);
        id_list.delete();
    endtask

    // Build a list mostly from consecutive runs, with zeros, near misses and
    // arbitrary identifiers mixed in. Some bases are drawn near zero and near the
    // top so that wrap-around and zero adjacency are hit often.
    task automatic build_random_list();
        int          len;
        int          kind;
        int          n;
        logic [31:0] base;
        len = $urandom_range(1, 12);
        while (id_list.size() < len)
        begin
            kind = $urandom_range(9);
            case ($urandom_range(7))
                0:       base = 32'hFFFF_FFFF - $urandom_range(4);
                1:       base = $urandom_range(3);
                default: base = $urandom;
            endcase
            if (kind < 6)
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    id_list.push_back(base + k);
            end
            else if (kind < 7)
            begin
                id_list.push_back(base);
                id_list.push_back(base + 32'd2);
            end
            else if (kind < 8)
                repeat ($urandom_range(1, 2)) id_list.push_back(32'd0);
            else
                id_list.push_back($urandom);
        end
        while (id_list.size() > len)
            void'(id_list.pop_back());
    endtask

    // Drop valid and hold off until every owed run word has been taken.
    task automatic drain_runs();
        id_valid <= 1'b0;
        @(posedge clk);
        while (runs_owed != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int idle_plan [4]  = '{0, 46, 0, 35};
        int stall_plan [4] = '{0, 0, 46, 35};
        sent_words = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            if (p == 0)
                foreach (directed_words[i])
                    push_id(directed_words[i][31:0], directed_words[i][32]);
            while (sent_words < PHASE_WORDS * (p + 1))
            begin
                build_random_list();
                send_list();
            end
            // Let the pipeline empty completely before the next idling pattern.
            drain_runs();
        end

        // Allow for any late or stray words past the last owed one.
        repeat (8) @(posedge clk);
        if (fault_count == 0 && runs_owed == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

### files.f
rtl/urr_pkg.sv
rtl/urr_core.sv
rtl/urr_outq.sv
rtl/uid_run_range_encoder.sv
sim/urr_run_checker.sv
sim/tb.sv
